/* rtl/core/hdpp_pkg.sv */
`timescale 1ns / 1ps

package hdpp_pkg;

    localparam int BufDepth = 20;
    localparam int AddrW    = 5;
    localparam int CountW   = 5;

    typedef logic [7:0]  byte_t;
    typedef logic [3:0]  nibble_t;
    typedef logic [2:0]  field_t;
    typedef logic [15:0] half_t;
    typedef logic [47:0] ssid_t;
    typedef logic [23:0] frame_t;

    // field codes, in payload order after the mask byte
    localparam field_t FLD_WAKE  = 3'd0;
    localparam field_t FLD_MODE  = 3'd1;
    localparam field_t FLD_SSID  = 3'd2;
    localparam field_t FLD_CYC   = 3'd3;
    localparam field_t FLD_FRAME = 3'd4;
    localparam field_t FLD_ACCEL = 3'd5;
    localparam field_t FLD_IND   = 3'd6;
    localparam field_t FLD_NONE  = 3'd7;

    localparam byte_t MODE_MASK = 8'h07;
    localparam byte_t LOW_MASK  = 8'h0F;

    function automatic nibble_t nibble_of(input byte_t c);
        nibble_t n;
        n = c[3:0];
        if (c >= 8'h61 && c <= 8'h66)
        begin
            n = 4'(c[3:0] + 4'd9);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            n = 4'(c[3:0] + 4'd9);
        end
        else
        begin
            n = 4'(c & LOW_MASK);
        end
        return n;
    endfunction

    // number of bytes in a field, minus one
    function automatic field_t field_last(input field_t f);
        field_t l;
        l = 3'd0;
        case (f)
            FLD_WAKE:  l = 3'd1;
            FLD_SSID:  l = 3'd5;
            FLD_FRAME: l = 3'd2;
            FLD_ACCEL: l = 3'd3;
            FLD_IND:   l = 3'd1;
            default:   l = 3'd0;
        endcase
        return l;
    endfunction

    // first present field at or after the given one
    function automatic field_t next_field(input byte_t mask, input field_t from);
        field_t f;
        f = FLD_NONE;
        for (int i = 6; i >= 0; i--)
        begin
            if (mask[i] && (3'(i) >= from))
            begin
                f = 3'(i);
            end
        end
        return f;
    endfunction

endpackage

/* rtl/core/hdpp_char_if.sv */
`timescale 1ns / 1ps

interface hdpp_char_if;
    import hdpp_pkg::*;

    logic  valid;
    logic  ready;
    byte_t hex_char;
    logic  last;

    modport source (output valid, output hex_char, output last, input ready);
    modport sink   (input valid, input hex_char, input last, output ready);
endinterface

/* rtl/core/hdpp_param_if.sv */
`timescale 1ns / 1ps

interface hdpp_param_if;
    import hdpp_pkg::*;

    logic         valid;
    logic         ready;
    byte_t        mask;
    half_t        node_id;
    half_t        wake_interval;
    logic [2:0]   mode;
    ssid_t        ssid;
    byte_t        cycle_count;
    frame_t       frame_counter;
    half_t        accel_rate;
    half_t        accel_samples;
    half_t        inductive_samples;
    logic [4:0]   byte_count;

    modport source (
        output valid, input ready,
        output mask, output node_id, output wake_interval, output mode, output ssid,
        output cycle_count, output frame_counter, output accel_rate,
        output accel_samples, output inductive_samples, output byte_count
    );
    modport sink (
        input valid, output ready,
        input mask, input node_id, input wake_interval, input mode, input ssid,
        input cycle_count, input frame_counter, input accel_rate,
        input accel_samples, input inductive_samples, input byte_count
    );
endinterface

/* rtl/core/hex_downlink_param_parser_core.sv */
`timescale 1ns / 1ps
// hex downlink parameter parser
// chars: one ascii hex character per request, last marks the end of a payload.
// params: one request per payload, carrying the mask, node id, every held
//   parameter and the number of bytes kept (0 to 20).
// characters are taken at one per cycle while the parser is idle; nibble
// pairs are written into a 20-entry byte memory with per-entry valid bits, so
// unreceived bytes read zero. after the last character the block sweeps the
// memory once, one address per cycle through its single registered read port,
// and shifts each byte into the field it belongs to, then registers the result.
// chars.ready is low during the sweep and until the result register is free,
// and the next character may be taken while a result waits. a stalled params
// receiver holds the result register and, after the next sweep, the parser
// too; the held values stay put until the next payload is swept.
// reset clears the nibble state, the byte count, all valid bits and every held
// parameter to zero; the held parameters survive from one payload to the next.
module hex_downlink_param_parser_core (
    input  logic                clk,
    input  logic                rst_n,
    hdpp_char_if.sink           chars,
    hdpp_param_if.source        params
);
    import hdpp_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;

    byte_t               mem [BufDepth];
    logic [BufDepth-1:0] vld_reg;
    byte_t               rd_data_reg;
    logic                rd_vld_reg;

    logic                pending_reg;
    nibble_t             high_reg;
    logic [CountW-1:0]   seen_reg;
    logic [CountW-1:0]   count_reg;

    logic [AddrW-1:0]    rd_cnt_reg;
    logic                proc_reg;
    logic [AddrW-1:0]    proc_pos_reg;
    field_t              fld_reg;
    field_t              sub_reg;
    byte_t               mask_reg;
    byte_t               node_hi_reg;
    byte_t               node_lo_reg;

    half_t               held_wake_reg;
    logic [2:0]          held_mode_reg;
    ssid_t               held_ssid_reg;
    byte_t               held_cycles_reg;
    frame_t              held_frame_reg;
    half_t               held_arate_reg;
    half_t               held_asamp_reg;
    half_t               held_ind_reg;

    logic                accept;
    logic                wr_en;
    byte_t               wr_byte;
    logic [CountW-1:0]   seen_next;
    logic                issue;
    byte_t               cur_byte;
    field_t              eff;
    logic                out_free;
    logic                sweep_done;

    assign accept     = chars.valid && chars.ready;
    assign chars.ready = (state_reg == ST_IDLE);
    assign wr_byte    = {high_reg, nibble_of(chars.hex_char)};
    assign wr_en      = accept && pending_reg && (seen_reg < CountW'(BufDepth));
    assign seen_next  = wr_en ? CountW'(seen_reg + 1'b1) : seen_reg;
    assign issue      = (state_reg == ST_WALK) && (rd_cnt_reg < AddrW'(BufDepth));
    assign cur_byte   = rd_vld_reg ? rd_data_reg : 8'h00;
    assign eff        = next_field(mask_reg, fld_reg);
    assign out_free   = !params.valid || params.ready;
    assign sweep_done = proc_reg && (proc_pos_reg == AddrW'(BufDepth - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && chars.last)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (sweep_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // byte memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[seen_reg] <= wr_byte;
        end
        rd_data_reg <= mem[rd_cnt_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            vld_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            pending_reg  <= 1'b0;
            high_reg     <= '0;
            seen_reg     <= '0;
            count_reg    <= '0;
            rd_cnt_reg   <= '0;
            proc_reg     <= 1'b0;
            proc_pos_reg <= '0;
            fld_reg      <= FLD_WAKE;
            sub_reg      <= '0;
            mask_reg     <= '0;
            node_hi_reg  <= '0;
            node_lo_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= issue ? vld_reg[rd_cnt_reg] : 1'b0;
            proc_reg   <= issue;
            if (issue)
            begin
                proc_pos_reg <= rd_cnt_reg;
                rd_cnt_reg   <= AddrW'(rd_cnt_reg + 1'b1);
            end

            if (accept)
            begin
                if (wr_en)
                begin
                    vld_reg[seen_reg] <= 1'b1;
                end
                if (chars.last)
                begin
                    // odd final nibble is dropped here
                    pending_reg <= 1'b0;
                    high_reg    <= '0;
                    count_reg   <= seen_next;
                    seen_reg    <= '0;
                    rd_cnt_reg  <= '0;
                    fld_reg     <= FLD_WAKE;
                    sub_reg     <= '0;
                end
                else
                begin
                    pending_reg <= !pending_reg;
                    high_reg    <= pending_reg ? 4'd0 : nibble_of(chars.hex_char);
                    seen_reg    <= seen_next;
                end
            end

            if (proc_reg)
            begin
                if (proc_pos_reg == '0)
                begin
                    mask_reg <= cur_byte;
                end
                else
                begin
                    if (proc_pos_reg == AddrW'(1))
                    begin
                        node_hi_reg <= cur_byte;
                    end
                    if (proc_pos_reg == AddrW'(2))
                    begin
                        node_lo_reg <= cur_byte;
                    end
                    if (eff != FLD_NONE)
                    begin
                        if (sub_reg == field_last(eff))
                        begin
                            fld_reg <= 3'(eff + 1'b1);
                            sub_reg <= '0;
                        end
                        else
                        begin
                            fld_reg <= eff;
                            sub_reg <= 3'(sub_reg + 1'b1);
                        end
                    end
                end
            end

            if (state_reg == ST_EMIT && out_free)
            begin
                vld_reg <= '0;
            end
        end
    end

    // held parameters, each field byte shifted in as it is swept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_wake_reg   <= '0;
            held_mode_reg   <= '0;
            held_ssid_reg   <= '0;
            held_cycles_reg <= '0;
            held_frame_reg  <= '0;
            held_arate_reg  <= '0;
            held_asamp_reg  <= '0;
            held_ind_reg    <= '0;
        end
        else if (proc_reg && proc_pos_reg != '0)
        begin
            unique case (eff)
                FLD_WAKE:  held_wake_reg <= {held_wake_reg[7:0], cur_byte};
                FLD_MODE:  held_mode_reg <= 3'(cur_byte & MODE_MASK);
                FLD_SSID:  held_ssid_reg <= {held_ssid_reg[39:0], cur_byte};
                FLD_CYC:   held_cycles_reg <= cur_byte;
                FLD_FRAME: held_frame_reg <= {held_frame_reg[15:0], cur_byte};
                FLD_ACCEL:
                begin
                    held_arate_reg <= {held_arate_reg[7:0], held_asamp_reg[15:8]};
                    held_asamp_reg <= {held_asamp_reg[7:0], cur_byte};
                end
                FLD_IND:   held_ind_reg <= {held_ind_reg[7:0], cur_byte};
                default:
                begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            params.valid <= 1'b0;
        end
        else if (state_reg == ST_EMIT && out_free)
        begin
            params.valid <= 1'b1;
        end
        else if (params.ready)
        begin
            params.valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT && out_free)
        begin
            params.mask              <= mask_reg;
            params.node_id           <= {node_hi_reg, node_lo_reg};
            params.wake_interval     <= held_wake_reg;
            params.mode              <= held_mode_reg;
            params.ssid              <= held_ssid_reg;
            params.cycle_count       <= held_cycles_reg;
            params.frame_counter     <= held_frame_reg;
            params.accel_rate        <= held_arate_reg;
            params.accel_samples     <= held_asamp_reg;
            params.inductive_samples <= held_ind_reg;
            params.byte_count        <= count_reg;
        end
    end

endmodule

/* sim/tb_hex_downlink_param_parser_core.sv */
`timescale 1ns / 1ps

module tb_hex_downlink_param_parser_core;
    import hdpp_pkg::*;

    typedef struct packed {
        byte_t      mask;
        half_t      node_id;
        half_t      wake_interval;
        logic [2:0] mode;
        ssid_t      ssid;
        byte_t      cycle_count;
        frame_t     frame_counter;
        half_t      accel_rate;
        half_t      accel_samples;
        half_t      inductive_samples;
        logic [4:0] byte_count;
    } param_set_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    hdpp_char_if  chars ();
    hdpp_param_if params ();

    hex_downlink_param_parser_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars),
        .params (params)
    );

    always #5 clk = ~clk;

    // shadow of the parser state
    param_set_t held        = '0;
    logic       nib_pending = 1'b0;
    nibble_t    hi_nib      = 4'h0;
    int         kept        = 0;
    byte_t      pay [BufDepth] = '{default: 8'h00};

    param_set_t pending_params [$];
    int         mismatches  = 0;
    int         chars_sent  = 0;
    int         hold_cycles = 0;
    logic       steady      = 1'b0;

    function automatic nibble_t hex_value(input byte_t c);
        if (c >= 8'h61 && c <= 8'h66)
        begin
            return 4'(c - 8'h57);
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            return 4'(c - 8'h37);
        end
        // digits and everything else keep their low nibble
        return c[3:0];
    endfunction

    function automatic byte_t pay_at(input int pos);
        return (pos < BufDepth) ? pay[pos] : 8'h00;
    endfunction

    function automatic void decode_char(input byte_t c, input logic is_last);
        nibble_t n;
        byte_t   m;
        int      pos;
        n = hex_value(c);
        if (!nib_pending)
        begin
            hi_nib      = n;
            nib_pending = 1'b1;
        end
        else
        begin
            if (kept < BufDepth)
            begin
                pay[kept] = {hi_nib, n};
                kept++;
            end
            nib_pending = 1'b0;
            hi_nib      = 4'h0;
        end
        if (is_last)
        begin
            m   = pay_at(0);
            pos = 1;
            if (m[FLD_WAKE])
            begin
                held.wake_interval = {pay_at(pos), pay_at(pos + 1)};
                pos += 2;
            end
            if (m[FLD_MODE])
            begin
                held.mode = 3'(pay_at(pos) & MODE_MASK);
                pos += 1;
            end
            if (m[FLD_SSID])
            begin
                held.ssid = {pay_at(pos), pay_at(pos + 1), pay_at(pos + 2),
                             pay_at(pos + 3), pay_at(pos + 4), pay_at(pos + 5)};
                pos += 6;
            end
            if (m[FLD_CYC])
            begin
                held.cycle_count = pay_at(pos);
                pos += 1;
            end
            if (m[FLD_FRAME])
            begin
                held.frame_counter = {pay_at(pos), pay_at(pos + 1), pay_at(pos + 2)};
                pos += 3;
            end
            if (m[FLD_ACCEL])
            begin
                held.accel_rate    = {pay_at(pos), pay_at(pos + 1)};
                held.accel_samples = {pay_at(pos + 2), pay_at(pos + 3)};
                pos += 4;
            end
            if (m[FLD_IND])
            begin
                held.inductive_samples = {pay_at(pos), pay_at(pos + 1)};
            end
            held.mask       = m;
            held.node_id    = {pay_at(1), pay_at(2)};
            held.byte_count = 5'(kept);
            pending_params.push_back(held);
            nib_pending = 1'b0;
            hi_nib      = 4'h0;
            kept        = 0;
            for (int i = 0; i < BufDepth; i++)
            begin
                pay[i] = 8'h00;
            end
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            if (mismatches < 10)
            begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
            end
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : check_params
        param_set_t got;
        param_set_t want;
        if (rst_n && params.valid && params.ready)
        begin
            got = '{params.mask, params.node_id, params.wake_interval, params.mode,
                    params.ssid, params.cycle_count, params.frame_counter,
                    params.accel_rate, params.accel_samples, params.inductive_samples,
                    params.byte_count};
            if (pending_params.size() == 0)
            begin
                if (mismatches < 10)
                begin
                    $display("%0t: unexpected params request, mask %0h", $realtime, got.mask);
                end
                mismatches++;
            end
            else
            begin
                want = pending_params.pop_front();
                check_field("mask", 64'(want.mask), 64'(got.mask));
                check_field("node_id", 64'(want.node_id), 64'(got.node_id));
                check_field("wake_interval", 64'(want.wake_interval),
                            64'(got.wake_interval));
                check_field("mode", 64'(want.mode), 64'(got.mode));
                check_field("ssid", 64'(want.ssid), 64'(got.ssid));
                check_field("cycle_count", 64'(want.cycle_count), 64'(got.cycle_count));
                check_field("frame_counter", 64'(want.frame_counter),
                            64'(got.frame_counter));
                check_field("accel_rate", 64'(want.accel_rate), 64'(got.accel_rate));
                check_field("accel_samples", 64'(want.accel_samples),
                            64'(got.accel_samples));
                check_field("inductive_samples", 64'(want.inductive_samples),
                            64'(got.inductive_samples));
                check_field("byte_count", 64'(want.byte_count), 64'(got.byte_count));
            end
        end
    end

    // mostly short gaps, a few long ones
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        params.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                params.ready <= 1'b0;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                params.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                params.ready <= 1'b1;
                if (!steady && $urandom_range(0, 5) == 0)
                begin
                    stall_left = idle_length();
                end
            end
        end
    end

    task automatic send_char(input byte_t c, input logic is_last);
        int gap;
        gap = steady ? 0 : idle_length();
        if (gap > 0)
        begin
            chars.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chars.valid    <= 1'b1;
        chars.hex_char <= c;
        chars.last     <= is_last;
        @(posedge clk);
        while (!chars.ready)
        begin
            @(posedge clk);
        end
        decode_char(c, is_last);
        chars_sent++;
    endtask

    task automatic send_stream(input byte_t cs[$]);
        for (int i = 0; i < cs.size(); i++)
        begin
            send_char(cs[i], i == cs.size() - 1);
        end
    endtask

    // sender goes quiet until every expected request has come back
    task automatic wait_drain();
        chars.valid <= 1'b0;
        @(posedge clk);
        while (pending_params.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic byte_t hex_char_of(input nibble_t n);
        if (n < 4'd10)
        begin
            return 8'h30 + {4'h0, n};
        end
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
    endfunction

    function automatic byte_t field_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int field_bytes(input field_t f);
        case (f)
            FLD_WAKE:  return 2;
            FLD_SSID:  return 6;
            FLD_FRAME: return 3;
            FLD_ACCEL: return 4;
            FLD_IND:   return 2;
            default:   return 1;
        endcase
    endfunction

    // mask byte followed by exactly the fields it announces
    function automatic void make_payload(input byte_t mask, output byte_t b[$]);
        b = {};
        b.push_back(mask);
        for (int f = FLD_WAKE; f <= FLD_IND; f++)
        begin
            if (mask[f])
            begin
                for (int k = 0; k < field_bytes(field_t'(f)); k++)
                begin
                    b.push_back(field_byte());
                end
            end
        end
    endfunction

    task automatic send_payload(input byte_t b[$], input logic odd_tail, input logic noisy);
        byte_t cs[$];
        foreach (b[i])
        begin
            cs.push_back(hex_char_of(b[i][7:4]));
            cs.push_back(hex_char_of(b[i][3:0]));
        end
        if (odd_tail || cs.size() == 0)
        begin
            cs.push_back(hex_char_of(4'($urandom_range(0, 15))));
        end
        if (noisy)
        begin
            cs[$urandom_range(0, cs.size() - 1)] = 8'($urandom_range(0, 255));
        end
        send_stream(cs);
    endtask

    task automatic test_reset_state();
        byte_t b[$];
        // a lone nibble is dropped: nothing kept, held values still at reset
        send_payload(b, 1'b1, 1'b0);
        b = '{8'h00};
        send_payload(b, 1'b0, 1'b0);
        wait_drain();
    endtask

    task automatic test_nibble_mapping();
        string s;
        byte_t cs[$];
        s = "0123456789abcdefABCDEFgG:/@`zZ";
        for (int i = 0; i < s.len(); i++)
        begin
            cs.push_back(s[i]);
        end
        cs.push_back(8'h00);
        cs.push_back(8'hFF);
        send_stream(cs);
        wait_drain();
    endtask

    task automatic test_each_field();
        byte_t b[$];
        for (int f = 0; f < 8; f++)
        begin
            make_payload(8'h01 << f, b);
            send_payload(b, 1'b0, 1'b0);
        end
        wait_drain();
    endtask

    task automatic test_extremes();
        byte_t b[$];
        b = {};
        repeat (20) b.push_back(8'hFF);
        send_payload(b, 1'b0, 1'b0);
        b = '{8'h7F};
        repeat (19) b.push_back(8'h00);
        send_payload(b, 1'b0, 1'b0);
        b = '{8'hFF};
        repeat (19) b.push_back(8'hFF);
        send_payload(b, 1'b1, 1'b0);
        wait_drain();
    endtask

    task automatic test_short_and_long();
        byte_t b[$];
        // all fields announced but only two bytes follow
        b = '{8'h7F, 8'h12, 8'h34};
        send_payload(b, 1'b0, 1'b0);
        // bytes past the twentieth are thrown away
        make_payload(8'h7F, b);
        repeat (6) b.push_back(field_byte());
        send_payload(b, 1'b1, 1'b0);
        wait_drain();
    endtask

    task automatic test_backpressure();
        byte_t b[$];
        steady      = 1'b1;
        hold_cycles = 400;
        for (int p = 0; p < 6; p++)
        begin
            make_payload(8'($urandom_range(0, 255)), b);
            send_payload(b, 1'b0, 1'b0);
        end
        wait_drain();
        steady = 1'b0;
    endtask

    task automatic test_random_payloads();
        byte_t b[$];
        byte_t cs[$];
        byte_t mask;
        int    target;
        int    kind;
        int    cut;
        target = 2000;
        while (chars_sent < target)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                steady = !steady;
            end
            if ($urandom_range(0, 24) == 0)
            begin
                wait_drain();
            end
            if ($urandom_range(0, 60) == 0)
            begin
                hold_cycles = $urandom_range(50, 200);
            end
            case ($urandom_range(0, 5))
                0:       mask = 8'h7F;
                1:       mask = 8'hFF;
                default: mask = 8'($urandom_range(0, 255));
            endcase
            make_payload(mask, b);
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                send_payload(b, $urandom_range(0, 7) == 0, 1'b0);
            end
            else if (kind == 7)
            begin
                // truncated payload
                cut = $urandom_range(1, b.size());
                repeat (cut) void'(b.pop_back());
                send_payload(b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            else if (kind == 8)
            begin
                // overlong payload with a stray character
                while (b.size() < 24)
                begin
                    b.push_back(field_byte());
                end
                send_payload(b, 1'($urandom_range(0, 1)), 1'b1);
            end
            else
            begin
                cs = {};
                repeat ($urandom_range(1, 50)) cs.push_back(8'($urandom_range(0, 255)));
                send_stream(cs);
            end
        end
    endtask

    initial
    begin : stimulus
        chars.valid    <= 1'b0;
        chars.hex_char <= 8'h00;
        chars.last     <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_reset_state();
        test_nibble_mapping();
        test_each_field();
        test_extremes();
        test_short_and_long();
        test_backpressure();
        test_random_payloads();
        wait_drain();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending_params.size() == 0)
        begin
            $display("tb_hex_downlink_param_parser_core: PASS");
        end
        else
        begin
            $display("tb_hex_downlink_param_parser_core: FAIL");
        end
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("tb_hex_downlink_param_parser_core: FAIL");
        $finish;
    end

endmodule
